/* hdl/cpvp_pkg.sv */
// Shared types, constants and codes for the cascade position/velocity PID.
package cpvp_pkg;

  localparam int OUTER_INTEGRAL_LIMIT = 65536;
  localparam int INNER_INTEGRAL_LIMIT = 65536;

  localparam int OUTER_THRESHOLD = 6554;   // 0.1 in Q16.16
  localparam int INNER_THRESHOLD = 32768;  // 0.5 in Q16.16
  localparam int STEP_FLOOR      = 4294;   // 1 us in Q0.32
  localparam int ALPHA_ONE       = 65536;
  localparam int DIV_STEPS       = 24;     // 48 quotient bits, two per cycle

  localparam int ADDR_W = 5;

  // register indexes
  localparam logic [2:0] REG_OUTER_KP = 3'd0;
  localparam logic [2:0] REG_OUTER_KI = 3'd1;
  localparam logic [2:0] REG_OUTER_KD = 3'd2;
  localparam logic [2:0] REG_INNER_KP = 3'd3;
  localparam logic [2:0] REG_INNER_KI = 3'd4;
  localparam logic [2:0] REG_INNER_KD = 3'd5;
  localparam logic [2:0] REG_VEL_LIM  = 3'd6;
  localparam logic [2:0] REG_ALPHA    = 3'd7;

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_ERR_O  = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_INT    = 4'd4;
  localparam logic [3:0] OP_SET_P  = 4'd5;
  localparam logic [3:0] OP_ADD_I  = 4'd6;
  localparam logic [3:0] OP_DSTART = 4'd7;
  localparam logic [3:0] OP_DIV    = 4'd8;
  localparam logic [3:0] OP_ADD_D  = 4'd9;
  localparam logic [3:0] OP_CLAMP  = 4'd10;
  localparam logic [3:0] OP_FILT1  = 4'd11;
  localparam logic [3:0] OP_FILT2  = 4'd12;
  localparam logic [3:0] OP_ERR_I  = 4'd13;
  localparam logic [3:0] OP_SAT    = 4'd14;

  // multiplier operand selects
  localparam logic [2:0] MS_ERR_DT = 3'd0;
  localparam logic [2:0] MS_KP     = 3'd1;
  localparam logic [2:0] MS_KI     = 3'd2;
  localparam logic [2:0] MS_KD     = 3'd3;
  localparam logic [2:0] MS_FILT_S = 3'd4;
  localparam logic [2:0] MS_FILT_C = 3'd5;

  typedef struct packed {
    logic signed [31:0] outer_kp;
    logic signed [31:0] outer_ki;
    logic signed [31:0] outer_kd;
    logic signed [31:0] inner_kp;
    logic signed [31:0] inner_ki;
    logic signed [31:0] inner_kd;
    logic [30:0]        velocity_limit;
    logic [16:0]        smoothing_alpha;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] msel;
    logic       inner;
    logic       load;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_stat_t;

endpackage

/* hdl/cpvp_regs.sv */
// APB-style configuration register file.
module cpvp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cpvp_pkg::cfg_t                cfg
);

  cpvp_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     idx;
  logic [16:0]    alpha_w;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;
  assign alpha_w = (pwdata[16:0] > 17'(cpvp_pkg::ALPHA_ONE)) ?
                   17'(cpvp_pkg::ALPHA_ONE) : pwdata[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_kp        <= '0;
      cfg_r.outer_ki        <= '0;
      cfg_r.outer_kd        <= '0;
      cfg_r.inner_kp        <= '0;
      cfg_r.inner_ki        <= '0;
      cfg_r.inner_kd        <= '0;
      cfg_r.velocity_limit  <= 31'd65536;
      cfg_r.smoothing_alpha <= 17'd16384;
    end else if (wr_en) begin
      case (idx)
        cpvp_pkg::REG_OUTER_KP: cfg_r.outer_kp        <= pwdata;
        cpvp_pkg::REG_OUTER_KI: cfg_r.outer_ki        <= pwdata;
        cpvp_pkg::REG_OUTER_KD: cfg_r.outer_kd        <= pwdata;
        cpvp_pkg::REG_INNER_KP: cfg_r.inner_kp        <= pwdata;
        cpvp_pkg::REG_INNER_KI: cfg_r.inner_ki        <= pwdata;
        cpvp_pkg::REG_INNER_KD: cfg_r.inner_kd        <= pwdata;
        cpvp_pkg::REG_VEL_LIM:  cfg_r.velocity_limit  <= pwdata[30:0];
        cpvp_pkg::REG_ALPHA:    cfg_r.smoothing_alpha <= alpha_w;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cpvp_pkg::REG_OUTER_KP: prdata = cfg_r.outer_kp;
      cpvp_pkg::REG_OUTER_KI: prdata = cfg_r.outer_ki;
      cpvp_pkg::REG_OUTER_KD: prdata = cfg_r.outer_kd;
      cpvp_pkg::REG_INNER_KP: prdata = cfg_r.inner_kp;
      cpvp_pkg::REG_INNER_KI: prdata = cfg_r.inner_ki;
      cpvp_pkg::REG_INNER_KD: prdata = cfg_r.inner_kd;
      cpvp_pkg::REG_VEL_LIM:  prdata = {1'b0, cfg_r.velocity_limit};
      cpvp_pkg::REG_ALPHA:    prdata = {15'd0, cfg_r.smoothing_alpha};
      default:                prdata = '0;
    endcase
  end

endmodule

/* hdl/cpvp_dp.sv */
// Datapath: shared multiplier, radix-4 divider, loop state and result register.
module cpvp_dp #(
  parameter int OUTER_INTEGRAL_LIMIT = cpvp_pkg::OUTER_INTEGRAL_LIMIT,
  parameter int INNER_INTEGRAL_LIMIT = cpvp_pkg::INNER_INTEGRAL_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpvp_pkg::cfg_t      cfg,
  input  cpvp_pkg::dp_cmd_t   cmd,
  output cpvp_pkg::dp_stat_t  stat,
  input  logic                in_mode,
  input  logic signed [31:0]  in_position_target,
  input  logic signed [31:0]  in_position_measured,
  input  logic signed [31:0]  in_velocity_measured,
  input  logic [31:0]         in_step_time,
  output logic signed [31:0]  out_torque_command,
  output logic signed [31:0]  out_velocity_command
);

  localparam logic signed [49:0] OUTER_BOUND = {2'b00, 32'(OUTER_INTEGRAL_LIMIT), 16'd0};
  localparam logic signed [49:0] INNER_BOUND = {2'b00, 32'(INNER_INTEGRAL_LIMIT), 16'd0};

  logic               mode_r;
  logic signed [31:0] tgt_r, pos_r, vel_r;
  logic [31:0]        dt_r;
  logic signed [32:0] err_r, diff_r;
  logic signed [47:0] acc_o_r, acc_i_r;
  logic signed [31:0] s_r, lastp_r, lastv_r, vcmd_r, torque_r;
  logic signed [63:0] sum_r;
  logic signed [67:0] prod_r;
  logic signed [49:0] filt_r;
  logic [31:0]        rem_r;
  logic [47:0]        num_r, quo_r;
  logic               neg_r, ovf_r, dzero_r;
  logic signed [31:0] out_t_r, out_v_r;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [31:0] kp, ki, kd;
  logic signed [47:0] acc;
  logic signed [32:0] thr;
  logic               in_win;
  logic signed [49:0] acc_sum, bound, acc_new;
  logic signed [67:0] p_sh;
  logic [47:0]        mabs;
  logic [32:0]        r1, r2;
  logic               ge1, ge2;
  logic [31:0]        rr1, rr2;
  logic [47:0]        mag;
  logic signed [63:0] dterm, vl, sat_hi, sat_lo;
  logic signed [49:0] fsum;
  logic [16:0]        alpha_c;

  assign stat.mode            = mode_r;
  assign out_torque_command   = out_t_r;
  assign out_velocity_command = out_v_r;

  always_comb begin
    kp  = cmd.inner ? cfg.inner_kp : cfg.outer_kp;
    ki  = cmd.inner ? cfg.inner_ki : cfg.outer_ki;
    kd  = cmd.inner ? cfg.inner_kd : cfg.outer_kd;
    acc = cmd.inner ? acc_i_r : acc_o_r;
    alpha_c = 17'(cpvp_pkg::ALPHA_ONE) - cfg.smoothing_alpha;
    case (cmd.msel)
      cpvp_pkg::MS_ERR_DT: begin
        ma = {err_r[32], err_r};
        mb = {2'b00, dt_r};
      end
      cpvp_pkg::MS_KP: begin
        ma = {{2{kp[31]}}, kp};
        mb = {err_r[32], err_r};
      end
      cpvp_pkg::MS_KI: begin
        ma = {{2{ki[31]}}, ki};
        mb = {{2{acc[47]}}, acc[47:16]};
      end
      cpvp_pkg::MS_KD: begin
        ma = {{2{kd[31]}}, kd};
        mb = {diff_r[32], diff_r};
      end
      cpvp_pkg::MS_FILT_S: begin
        ma = {17'd0, alpha_c};
        mb = {{2{s_r[31]}}, s_r};
      end
      cpvp_pkg::MS_FILT_C: begin
        ma = {17'd0, cfg.smoothing_alpha};
        mb = {{2{vcmd_r[31]}}, vcmd_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;

    // integral window and clamp
    thr     = cmd.inner ? 33'(cpvp_pkg::INNER_THRESHOLD) : 33'(cpvp_pkg::OUTER_THRESHOLD);
    in_win  = (err_r > -thr) && (err_r < thr);
    bound   = cmd.inner ? INNER_BOUND : OUTER_BOUND;
    acc_sum = {{2{acc[47]}}, acc} + {{16{prod_r[49]}}, prod_r[49:16]};
    if (acc_sum > bound)       acc_new = bound;
    else if (acc_sum < -bound) acc_new = -bound;
    else                       acc_new = acc_sum;

    // derivative numerator magnitude
    p_sh = prod_r >>> 16;
    mabs = prod_r[67] ? 48'(-p_sh) : 48'(p_sh);

    // two restoring division steps
    r1  = {rem_r, num_r[47]};
    ge1 = r1 >= {1'b0, dt_r};
    rr1 = ge1 ? 32'(r1 - {1'b0, dt_r}) : r1[31:0];
    r2  = {rr1, num_r[46]};
    ge2 = r2 >= {1'b0, dt_r};
    rr2 = ge2 ? 32'(r2 - {1'b0, dt_r}) : r2[31:0];

    mag   = ovf_r ? 48'hFFFF_FFFF_FFFF : quo_r;
    dterm = dzero_r ? 64'sd0 : (neg_r ? $signed({16'd0, mag}) : -$signed({16'd0, mag}));

    vl     = $signed({33'd0, cfg.velocity_limit});
    sat_hi = 64'sd2147483647;
    sat_lo = -64'sd2147483648;
    fsum   = filt_r + prod_r[49:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      tgt_r  <= in_position_target;
      pos_r  <= in_position_measured;
      vel_r  <= in_velocity_measured;
      dt_r   <= in_step_time;
    end
    if (cmd.out_load) begin
      out_t_r <= torque_r;
      out_v_r <= s_r;
    end
    if (!rst_n) begin
      // loop state starts from zero
      acc_o_r  <= '0;
      acc_i_r  <= '0;
      s_r      <= '0;
      lastp_r  <= '0;
      lastv_r  <= '0;
      torque_r <= '0;
    end else begin
      case (cmd.op)
        cpvp_pkg::OP_CLEAR: begin
          acc_o_r  <= '0;
          acc_i_r  <= '0;
          s_r      <= '0;
          lastp_r  <= '0;
          lastv_r  <= '0;
          torque_r <= '0;
        end
        cpvp_pkg::OP_ERR_O: begin
          err_r   <= 33'(tgt_r) - 33'(pos_r);
          diff_r  <= 33'(pos_r) - 33'(lastp_r);
          lastp_r <= pos_r;
        end
        cpvp_pkg::OP_MUL: prod_r <= prod;
        cpvp_pkg::OP_INT: begin
          if (in_win) begin
            if (cmd.inner) acc_i_r <= acc_new[47:0];
            else           acc_o_r <= acc_new[47:0];
          end
        end
        cpvp_pkg::OP_SET_P: sum_r <= 64'(prod_r >>> 16);
        cpvp_pkg::OP_ADD_I: sum_r <= sum_r + 64'(prod_r >>> 16);
        cpvp_pkg::OP_DSTART: begin
          neg_r   <= prod_r[67];
          ovf_r   <= mabs[47:16] >= dt_r;
          dzero_r <= dt_r <= 32'(cpvp_pkg::STEP_FLOOR);
          rem_r   <= mabs[47:16];
          num_r   <= {mabs[15:0], 32'd0};
          quo_r   <= '0;
        end
        cpvp_pkg::OP_DIV: begin
          rem_r <= rr2;
          num_r <= {num_r[45:0], 2'b00};
          quo_r <= {quo_r[45:0], ge1, ge2};
        end
        cpvp_pkg::OP_ADD_D: sum_r <= sum_r + dterm;
        cpvp_pkg::OP_CLAMP: begin
          if (sum_r > vl)       vcmd_r <= vl[31:0];
          else if (sum_r < -vl) vcmd_r <= 32'(-vl);
          else                  vcmd_r <= sum_r[31:0];
        end
        cpvp_pkg::OP_FILT1: filt_r <= prod_r[49:0];
        cpvp_pkg::OP_FILT2: s_r <= fsum[47:16];
        cpvp_pkg::OP_ERR_I: begin
          err_r   <= 33'(s_r) - 33'(vel_r);
          diff_r  <= 33'(vel_r) - 33'(lastv_r);
          lastv_r <= vel_r;
        end
        cpvp_pkg::OP_SAT: begin
          if (sum_r > sat_hi)      torque_r <= 32'sh7FFF_FFFF;
          else if (sum_r < sat_lo) torque_r <= 32'sh8000_0000;
          else                     torque_r <= sum_r[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/cpvp_ctrl.sv */
// Sequencer: steps the datapath through both loops and owns the handshakes.
module cpvp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cpvp_pkg::dp_stat_t  stat,
  output cpvp_pkg::dp_cmd_t   cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DECIDE = 5'd1;
  localparam logic [4:0] ST_CLR    = 5'd2;
  localparam logic [4:0] ST_ERR_O  = 5'd3;
  localparam logic [4:0] ST_M_IDT  = 5'd4;
  localparam logic [4:0] ST_INT    = 5'd5;
  localparam logic [4:0] ST_M_KP   = 5'd6;
  localparam logic [4:0] ST_P      = 5'd7;
  localparam logic [4:0] ST_M_KI   = 5'd8;
  localparam logic [4:0] ST_I      = 5'd9;
  localparam logic [4:0] ST_M_KD   = 5'd10;
  localparam logic [4:0] ST_DSTART = 5'd11;
  localparam logic [4:0] ST_DIV    = 5'd12;
  localparam logic [4:0] ST_DADD   = 5'd13;
  localparam logic [4:0] ST_CLAMP  = 5'd14;
  localparam logic [4:0] ST_M_FS   = 5'd15;
  localparam logic [4:0] ST_F1     = 5'd16;
  localparam logic [4:0] ST_M_FC   = 5'd17;
  localparam logic [4:0] ST_F2     = 5'd18;
  localparam logic [4:0] ST_ERR_I  = 5'd19;
  localparam logic [4:0] ST_SAT    = 5'd20;
  localparam logic [4:0] ST_DONE   = 5'd21;

  localparam int CW = $clog2(cpvp_pkg::DIV_STEPS);

  logic [4:0]    state_r, state_nxt;
  logic          inner_r, inner_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    inner_nxt    = inner_r;
    cnt_nxt      = cnt_r;
    cmd.op       = cpvp_pkg::OP_NOP;
    cmd.msel     = cpvp_pkg::MS_ERR_DT;
    cmd.inner    = inner_r;
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        inner_nxt = 1'b0;
        state_nxt = stat.mode ? ST_CLR : ST_ERR_O;
      end
      ST_CLR: begin
        cmd.op    = cpvp_pkg::OP_CLEAR;
        state_nxt = ST_DONE;
      end
      ST_ERR_O: begin
        cmd.op    = cpvp_pkg::OP_ERR_O;
        state_nxt = ST_M_IDT;
      end
      ST_M_IDT: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_ERR_DT;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.op    = cpvp_pkg::OP_INT;
        state_nxt = ST_M_KP;
      end
      ST_M_KP: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_KP;
        state_nxt = ST_P;
      end
      ST_P: begin
        cmd.op    = cpvp_pkg::OP_SET_P;
        state_nxt = ST_M_KI;
      end
      ST_M_KI: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_KI;
        state_nxt = ST_I;
      end
      ST_I: begin
        cmd.op    = cpvp_pkg::OP_ADD_I;
        state_nxt = ST_M_KD;
      end
      ST_M_KD: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_KD;
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.op    = cpvp_pkg::OP_DSTART;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = cpvp_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(cpvp_pkg::DIV_STEPS - 1)) state_nxt = ST_DADD;
      end
      ST_DADD: begin
        cmd.op    = cpvp_pkg::OP_ADD_D;
        state_nxt = inner_r ? ST_SAT : ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op    = cpvp_pkg::OP_CLAMP;
        state_nxt = ST_M_FS;
      end
      ST_M_FS: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_FILT_S;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.op    = cpvp_pkg::OP_FILT1;
        state_nxt = ST_M_FC;
      end
      ST_M_FC: begin
        cmd.op    = cpvp_pkg::OP_MUL;
        cmd.msel  = cpvp_pkg::MS_FILT_C;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        cmd.op    = cpvp_pkg::OP_FILT2;
        state_nxt = ST_ERR_I;
      end
      ST_ERR_I: begin
        cmd.op    = cpvp_pkg::OP_ERR_I;
        inner_nxt = 1'b1;
        state_nxt = ST_M_IDT;
      end
      ST_SAT: begin
        cmd.op    = cpvp_pkg::OP_SAT;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inner_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inner_r     <= inner_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/cascade_position_velocity_pid.sv */
// Top level of the single-joint cascade position/velocity PID controller.
// One beat in gives one beat out. A control step (mode 0) runs both loops from
// acceptance until the result is loaded into the output register; a clear
// (mode 1) zeroes the loop state. The block then takes the next beat the cycle
// after the load. The step time is set by the single shared 34x34 multiplier,
// used ten times, and by the radix-4 restoring divider that forms each
// derivative term, once for the position loop and once for the velocity loop.
// The finished result sits in its own register, so a new beat is accepted
// while the previous result still waits on out_ready. Gains are written through
// the APB-style port at 4-byte spacing and should only be changed while idle.
module cascade_position_velocity_pid #(
  parameter int OUTER_INTEGRAL_LIMIT = cpvp_pkg::OUTER_INTEGRAL_LIMIT,
  parameter int INNER_INTEGRAL_LIMIT = cpvp_pkg::INNER_INTEGRAL_LIMIT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input beat
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [31:0]           in_position_target,
  input  logic signed [31:0]           in_position_measured,
  input  logic signed [31:0]           in_velocity_measured,
  input  logic [31:0]                  in_step_time,
  // result beat
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_torque_command,
  output logic signed [31:0]           out_velocity_command,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cpvp_pkg::cfg_t     cfg;
  cpvp_pkg::dp_cmd_t  cmd;
  cpvp_pkg::dp_stat_t stat;

  // gain, limit and filter weight registers
  cpvp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: outer loop, filter, then inner loop on the same hardware
  cpvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and loop state
  cpvp_dp #(
    .OUTER_INTEGRAL_LIMIT (OUTER_INTEGRAL_LIMIT),
    .INNER_INTEGRAL_LIMIT (INNER_INTEGRAL_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_mode              (in_mode),
    .in_position_target   (in_position_target),
    .in_position_measured (in_position_measured),
    .in_velocity_measured (in_velocity_measured),
    .in_step_time         (in_step_time),
    .out_torque_command   (out_torque_command),
    .out_velocity_command (out_velocity_command)
  );

endmodule

/* hdl/cpvp_chk.sv */
// Port-level checker for the cascade PID, bound to the top level.
module cpvp_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [31:0]           out_torque_command,
  input logic signed [31:0]           out_velocity_command
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_torque_command)
                                && $stable(out_velocity_command))
    else $error("result changed while stalled");

  // one beat at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while busy");

  // a new result only appears while the block is working on a beat
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared from idle");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind cascade_position_velocity_pid cpvp_chk u_chk (.*);

/* tb/cascade_position_velocity_pid_tb.sv */
// Self-checking testbench for the single-joint cascade position/velocity PID.
`timescale 1ns / 100ps

module cascade_position_velocity_pid_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               mode;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic signed [31:0] velocity;
    logic [31:0]        dt;
  } joint_beat_t;

  typedef struct {
    logic signed [31:0] torque;
    logic signed [31:0] vel_cmd;
  } joint_result_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam wide_t DERIV_MAX = (wide_t'(1) <<< 48) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = 1'b0;
  logic signed [31:0] in_position_target = '0;
  logic signed [31:0] in_position_measured = '0;
  logic signed [31:0] in_velocity_measured = '0;
  logic [31:0]        in_step_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_torque_command;
  logic signed [31:0] out_velocity_command;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [cpvp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  cascade_position_velocity_pid i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_position_target   (in_position_target),
    .in_position_measured (in_position_measured),
    .in_velocity_measured (in_velocity_measured),
    .in_step_time         (in_step_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_torque_command   (out_torque_command),
    .out_velocity_command (out_velocity_command),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #2 clk = ~clk;

  // Beats waiting for the driver, and results the controller owes us.
  joint_beat_t   pending_beats[$];
  joint_result_t expected_results[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  // Local copy of the gains and limits.
  wide_t g_okp, g_oki, g_okd, g_ikp, g_iki, g_ikd, g_vlim, g_alpha;
  // Local copy of the loop state.
  wide_t s_oint, s_iint, s_smooth, s_lastpos, s_lastvel;

  function automatic wide_t clampw(wide_t v, wide_t lo, wide_t hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Integrate only inside the error window, then clamp to the limit.
  function automatic wide_t integrate(wide_t acc, wide_t err, wide_t thr, wide_t dtw,
                                      wide_t lim);
    wide_t bound;
    bound = lim * 65536;
    if (err > -thr && err < thr) begin
      return clampw(acc + ((err * dtw) >>> 16), -bound, bound);
    end
    return acc;
  endfunction

  // Derivative on measurement: -(kd*diff) / dt, magnitude capped at 48 bits.
  function automatic wide_t deriv_term(wide_t kd, wide_t diff, wide_t dtw);
    wide_t p, m, mag;
    if (dtw <= cpvp_pkg::STEP_FLOOR) return 0;
    p = (kd * diff) >>> 16;
    m = p < 0 ? -p : p;
    mag = (m <<< 32) / dtw;
    if (mag > DERIV_MAX) mag = DERIV_MAX;
    return p < 0 ? mag : -mag;
  endfunction

  function automatic wide_t pid_out(wide_t kp, wide_t ki, wide_t kd, wide_t err,
                                    wide_t acc, wide_t diff, wide_t dtw);
    return ((kp * err) >>> 16) + ((ki * (acc >>> 16)) >>> 16) + deriv_term(kd, diff, dtw);
  endfunction

  // Advance the local loop state by one beat (or clear it) and return the torque and velocity command it gives.
  function automatic joint_result_t control_step(joint_beat_t b);
    joint_result_t r;
    wide_t tgt, pos, vel, dtw, err, cmd, verr, tq;
    tgt = b.target;
    pos = b.measured;
    vel = b.velocity;
    dtw = $signed({96'd0, b.dt});
    if (b.mode) begin
      s_oint = 0; s_iint = 0; s_smooth = 0; s_lastpos = 0; s_lastvel = 0;
      r.torque = '0;
      r.vel_cmd = '0;
      return r;
    end
    err = tgt - pos;
    s_oint = integrate(s_oint, err, cpvp_pkg::OUTER_THRESHOLD, dtw,
                       cpvp_pkg::OUTER_INTEGRAL_LIMIT);
    cmd = pid_out(g_okp, g_oki, g_okd, err, s_oint, pos - s_lastpos, dtw);
    cmd = clampw(cmd, -g_vlim, g_vlim);
    s_lastpos = pos;
    s_smooth = ((cpvp_pkg::ALPHA_ONE - g_alpha) * s_smooth + g_alpha * cmd) >>> 16;
    verr = s_smooth - vel;
    s_iint = integrate(s_iint, verr, cpvp_pkg::INNER_THRESHOLD, dtw,
                       cpvp_pkg::INNER_INTEGRAL_LIMIT);
    tq = pid_out(g_ikp, g_iki, g_ikd, verr, s_iint, vel - s_lastvel, dtw);
    tq = clampw(tq, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
    s_lastvel = vel;
    r.torque = tq[31:0];
    r.vel_cmd = s_smooth[31:0];
    return r;
  endfunction

  // Driver: hold the beat until accepted, then maybe idle before the next one.
  int src_gap = 0;
  always @(posedge clk) begin
    joint_beat_t b;
    logic        next_valid;
    cycles <= cycles + 1;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        b.mode = in_mode;
        b.target = in_position_target;
        b.measured = in_position_measured;
        b.velocity = in_velocity_measured;
        b.dt = in_step_time;
        expected_results.push_back(control_step(b));
        next_valid = 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 3);
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          in_mode <= b.mode;
          in_position_target <= b.target;
          in_position_measured <= b.measured;
          in_velocity_measured <= b.velocity;
          in_step_time <= b.dt;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: random out_ready stalls, compare each result beat in order.
  int sink_stall = 0;
  always @(posedge clk) begin
    joint_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: torque %0d vel %0d",
                                        out_torque_command, out_velocity_command);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (e.torque !== out_torque_command || e.vel_cmd !== out_velocity_command) begin
            if (mismatches < 10)
              $display("mismatch: torque exp %0d got %0d, vel_cmd exp %0d got %0d",
                       e.torque, out_torque_command, e.vel_cmd, out_velocity_command);
            mismatches++;
          end
        end
      end
      if (no_idle) begin
        out_ready <= 1'b1;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) sink_stall = $urandom_range(1, 3);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("cascade_position_velocity_pid_tb: done, errors");
      $finish;
    end
  end

  // APB write: setup, access, register taken on the access edge.
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cpvp_pkg::REG_OUTER_KP: g_okp = $signed(value);
      cpvp_pkg::REG_OUTER_KI: g_oki = $signed(value);
      cpvp_pkg::REG_OUTER_KD: g_okd = $signed(value);
      cpvp_pkg::REG_INNER_KP: g_ikp = $signed(value);
      cpvp_pkg::REG_INNER_KI: g_iki = $signed(value);
      cpvp_pkg::REG_INNER_KD: g_ikd = $signed(value);
      cpvp_pkg::REG_VEL_LIM:  g_vlim = {97'd0, value[30:0]};
      cpvp_pkg::REG_ALPHA:
        g_alpha = value[16:0] > cpvp_pkg::ALPHA_ONE ? cpvp_pkg::ALPHA_ONE
                                                    : {111'd0, value[16:0]};
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] okp, logic [31:0] oki, logic [31:0] okd,
                           logic [31:0] ikp, logic [31:0] iki, logic [31:0] ikd,
                           logic [31:0] vlim, logic [31:0] alpha);
    reg_write(cpvp_pkg::REG_OUTER_KP, okp);
    reg_write(cpvp_pkg::REG_OUTER_KI, oki);
    reg_write(cpvp_pkg::REG_OUTER_KD, okd);
    reg_write(cpvp_pkg::REG_INNER_KP, ikp);
    reg_write(cpvp_pkg::REG_INNER_KI, iki);
    reg_write(cpvp_pkg::REG_INNER_KD, ikd);
    reg_write(cpvp_pkg::REG_VEL_LIM, vlim);
    reg_write(cpvp_pkg::REG_ALPHA, alpha);
  endtask

  // Wait until every beat is in and answered, then let the pipe settle.
  task automatic drain();
    while (pending_beats.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic joint_beat_t make_beat(logic m, int tgt, int pos, int vel,
                                            logic [31:0] dt);
    joint_beat_t b;
    b.mode = m; b.target = tgt; b.measured = pos; b.velocity = vel; b.dt = dt;
    return b;
  endfunction

  // Mostly plausible servo beats near the setpoint, with some noise.
  function automatic joint_beat_t random_beat();
    joint_beat_t b;
    int k;
    k = $urandom_range(0, 19);
    b.mode = 1'b0;
    b.target = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    b.measured = b.target + $signed($urandom_range(0, 16000)) - 8000;
    b.velocity = $signed($urandom_range(0, 80000)) - 40000;
    b.dt = $urandom_range(3000000, 6000000);
    if (k == 0) begin
      b.mode = 1'b1;
      b.target = $urandom; b.measured = $urandom; b.velocity = $urandom;
      b.dt = $urandom;
    end else if (k < 3) begin
      b.target = $urandom; b.measured = $urandom; b.velocity = $urandom;
      b.dt = $urandom;
    end else if (k == 3) begin
      b.dt = $urandom_range(0, 4295);
    end else if (k == 4) begin
      b.dt = $urandom;
    end
    return b;
  endfunction

  initial begin
    g_okp = 0; g_oki = 0; g_okd = 0; g_ikp = 0; g_iki = 0; g_ikd = 0;
    g_vlim = 65536; g_alpha = 16384;
    s_oint = 0; s_iint = 0; s_smooth = 0; s_lastpos = 0; s_lastvel = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: moderate gains, extremes of each field, clear and short steps.
    write_all(32'h0002_0000, 32'h0001_0000, 32'h0000_1000, 32'h0001_8000,
              32'h0000_8000, 32'h0000_0800, 32'h0004_0000, 32'h0000_4000);
    pending_beats.push_back(make_beat(1'b0, 100, 0, 0, 32'd4_294_967));
    pending_beats.push_back(make_beat(1'b0, 200, 50, 30, 32'd4294));
    pending_beats.push_back(make_beat(1'b0, 300, 60, 40, 32'd4295));
    pending_beats.push_back(make_beat(1'b0, 0, 0, 0, 32'd0));
    pending_beats.push_back(make_beat(1'b0, 6553, 0, 0, 32'hFFFF_FFFF));
    pending_beats.push_back(make_beat(1'b0, 6554, 0, 0, 32'hFFFF_FFFF));
    pending_beats.push_back(make_beat(1'b0, 0, 6554, 32767, 32'd5_000_000));
    pending_beats.push_back(make_beat(1'b0, 0, 0, -32768, 32'd5_000_000));
    pending_beats.push_back(make_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'd4295));
    pending_beats.push_back(make_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'd4295));
    pending_beats.push_back(make_beat(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'hFFFF_FFFF));
    pending_beats.push_back(make_beat(1'b0, 1000, 900, 10, 32'd4_000_000));
    pending_beats.push_back(make_beat(1'b0, -1000, -900, -10, 32'd4_000_000));
    pending_beats.push_back(make_beat(1'b1, 0, 0, 0, 32'd0));
    pending_beats.push_back(make_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'd1));
    drain();

    // Random phases over a spread of register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
        1: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);  // alpha above one, masked limit
        default: write_all($urandom_range(0, 32'h8_0000) - 32'h4_0000,
                           $urandom_range(0, 32'h4_0000) - 32'h2_0000,
                           $urandom_range(0, 32'h1_0000) - 32'h8000,
                           $urandom_range(0, 32'h8_0000) - 32'h4_0000,
                           $urandom_range(0, 32'h4_0000) - 32'h2_0000,
                           $urandom_range(0, 32'h1_0000) - 32'h8000,
                           $urandom_range(0, 32'h8_0000), $urandom_range(0, 32'h1_0000));
      endcase
      // The final stretch runs flat out on both sides.
      if (ph == 5) no_idle = 1'b1;
      for (int n = 0; n < 82; n++) pending_beats.push_back(random_beat());
      drain();
    end

    if (mismatches == 0) begin
      $display("cascade_position_velocity_pid_tb: done, clean");
    end else begin
      $display("cascade_position_velocity_pid_tb: done, errors");
    end
    $finish;
  end

endmodule
